// ----- hw/rtl/olie_pkg.sv -----
// olie_pkg: shared types and codes for the ordered list insert engine
// holds command and status codes, cell operations, state encoding and payload structs
// no dependencies
package olie_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned POS_W   = 7;
	localparam int unsigned EIDX_W  = 6;

	typedef enum logic [1:0] {
		CMD_INS_FRONT = 2'd0,
		CMD_INS_END   = 2'd1,
		CMD_INS_POS   = 2'd2,
		CMD_READ      = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_INVALID = 3'd1,
		STAT_BEYOND  = 3'd2,
		STAT_FULL    = 3'd3,
		STAT_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ROTATE
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		cmd_code_t                 command;
		logic signed [DATA_W-1:0]  value;
		logic        [POS_W-1:0]   position;
	} cmd_item_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  element;
		logic        [EIDX_W-1:0]  element_index;
		logic                      last;
	} rsp_item_t;

endpackage

// ----- hw/rtl/olie_cell.sv -----
// olie_cell: one storage cell of the list chain
// shifts right on insert, rotates toward the head on readout
// depends on olie_pkg
module olie_cell import olie_pkg::*; #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned IDX_W = 6
) (
	input  logic                      clk,
	input  cell_op_t                  op,
	input  logic        [IDX_W-1:0]   slot,
	input  logic        [IDX_W-1:0]   tail,
	input  logic signed [DATA_W-1:0]  value,
	input  logic signed [DATA_W-1:0]  left,
	input  logic signed [DATA_W-1:0]  right,
	input  logic signed [DATA_W-1:0]  head,
	output logic signed [DATA_W-1:0]  data
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_INSERT: begin
				if (MY_IDX == slot) begin
					data_q <= value;
				end else if (MY_IDX > slot) begin
					data_q <= left;
				end
			end
			CELL_ROTATE: begin
				if (MY_IDX == tail) begin
					data_q <= head;
				end else begin
					data_q <= right;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

// ----- hw/rtl/ordered_list_insert_engine_core.sv -----
// ordered_list_insert_engine_core: ordered list of signed values kept in a chain of cells
// decodes commands, checks positions, steers the cells and registers each response
// depends on olie_pkg and olie_cell
//
//   port group   direction   payload        transfer when
//   cmd          in          cmd_item_t     cmd_valid && cmd_ready
//   rsp          out         rsp_item_t     rsp_valid && rsp_ready
//
// an insert updates the chain when the command is taken; its status is registered and shown the next cycle
// during a readout one element leaves the head cell per cycle while rsp is not stalled, and
// the chain rotates with it, so the list is back in order after the last element
// a stalled rsp holds the chain; cmd_ready stays low during readout and until the response
// register can take a new item; reset empties the list at once; no clearing pass
module ordered_list_insert_engine_core import olie_pkg::*; #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_item_t  cmd,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_item_t  rsp
);

	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

	state_t                    state_q, state_d;
	logic        [LEN_W-1:0]   len_q, len_d;
	logic        [IDX_W-1:0]   cnt_q, cnt_d;
	logic                      rsp_valid_q;
	rsp_item_t                 rsp_q, rsp_d;
	logic                      load;
	logic                      out_free;
	logic                      full;
	logic                      rd_last;
	logic        [CMP_W-1:0]   pos_m1;
	cell_op_t                  cell_op;
	logic        [IDX_W-1:0]   slot;
	logic        [IDX_W-1:0]   tail;
	logic signed [DATA_W-1:0]  cell_q [CAPACITY];

	// chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = cmd.value;
		end else begin : g_mid_l
			assign left_w = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_w = cell_q[0];
		end else begin : g_mid_r
			assign right_w = cell_q[i+1];
		end
		olie_cell #(
			.INDEX (i),
			.IDX_W (IDX_W)
		) u_cell (
			.clk   (clk),
			.op    (cell_op),
			.slot  (slot),
			.tail  (tail),
			.value (cmd.value),
			.left  (left_w),
			.right (right_w),
			.head  (cell_q[0]),
			.data  (cell_q[i])
		);
	end

	assign out_free = !rsp_valid_q || rsp_ready;
	assign full     = (len_q == LEN_W'(CAPACITY));
	assign pos_m1   = CMP_W'(cmd.position) - CMP_W'(1);
	assign rd_last  = ((LEN_W'(cnt_q) + LEN_W'(1)) == len_q);
	assign tail     = IDX_W'(len_q - LEN_W'(1));

	always_comb begin
		state_d   = state_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		load      = 1'b0;
		rsp_d     = '0;
		cell_op   = CELL_HOLD;
		slot      = '0;
		cmd_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = out_free;
				if (cmd_valid && out_free) begin
					load       = 1'b1;
					rsp_d.last = 1'b1;
					case (cmd.command)
						CMD_INS_FRONT, CMD_INS_END: begin
							if (full) begin
								rsp_d.status = STAT_FULL;
							end else begin
								rsp_d.status = STAT_OK;
								cell_op      = CELL_INSERT;
								slot         = (cmd.command == CMD_INS_END) ?
								               IDX_W'(len_q) : '0;
								len_d        = len_q + LEN_W'(1);
							end
						end
						CMD_INS_POS: begin
							if (cmd.position == '0) begin
								rsp_d.status = STAT_INVALID;
							end else if (pos_m1 > CMP_W'(len_q)) begin
								rsp_d.status = STAT_BEYOND;
							end else if (full) begin
								rsp_d.status = STAT_FULL;
							end else begin
								rsp_d.status = STAT_OK;
								cell_op      = CELL_INSERT;
								slot         = IDX_W'(pos_m1);
								len_d        = len_q + LEN_W'(1);
							end
						end
						CMD_READ: begin
							if (len_q == '0) begin
								rsp_d.status = STAT_EMPTY;
							end else begin
								load    = 1'b0;
								cnt_d   = '0;
								state_d = ST_READ;
							end
						end
						default: begin
							rsp_d.status = STAT_INVALID;
						end
					endcase
				end
			end
			ST_READ: begin
				if (out_free) begin
					load                = 1'b1;
					rsp_d.status        = STAT_OK;
					rsp_d.element       = cell_q[0];
					rsp_d.element_index = EIDX_W'(cnt_q);
					rsp_d.last          = rd_last;
					cell_op             = CELL_ROTATE;
					cnt_d               = cnt_q + IDX_W'(1);
					if (rd_last) begin
						cnt_d   = '0;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(CAPACITY))
		else $error("list length above capacity");

	a_read_blocks_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !cmd_ready)
		else $error("command taken during readout");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_op == CELL_INSERT) |=> (len_q == $past(len_q) + LEN_W'(1)))
		else $error("insert did not grow the list");

	a_read_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && load && rd_last) |=> (state_q == ST_IDLE))
		else $error("readout did not end after last element");

	a_read_keeps_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> $stable(len_q))
		else $error("length changed during readout");

endmodule
